>>> sv/krt_pkg.sv
// Package for the keyed record table: field types, operation and status codes,
// and the result record passed from the sequencer to the output stage.
// No dependencies.
`default_nettype none

package krt_pkg;

    // Default number of table entries.
    localparam int DEPTH_DEF = 64;

    // Fixed field widths of the command and response transactions.
    localparam int FUNC_W = 2;
    localparam int KEY_W  = 32;
    localparam int POS_W  = 6;
    localparam int BYTE_W = 8;
    localparam int PAY_W  = 4 * BYTE_W;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 6;
    localparam int FILL_W = 7;

    // One stored record is the payload above the key.
    localparam int REC_W  = PAY_W + KEY_W;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [PAY_W-1:0]  pay_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [POS_W-1:0]  pos_t;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_READ   = 2'd2,
        FN_NOP    = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_RDATA,
        S_DONE
    } state_t;

    // Finished result handed to the output register.
    typedef struct packed {
        status_t status;
        slot_t   slot;
        fill_t   fill;
        key_t    key;
        pay_t    pay;
    } res_t;

endpackage

`default_nettype wire

>>> sv/krt_if.sv
// Channel interfaces of the keyed record table: command and response.
// Depends on krt_pkg for the field widths.
`default_nettype none

// Command channel: operation, key, read position and insert payload.
interface krt_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [krt_pkg::FUNC_W-1:0]  func;
    logic [krt_pkg::KEY_W-1:0]   key;
    logic [krt_pkg::POS_W-1:0]   position;
    logic [krt_pkg::BYTE_W-1:0]  value_a;
    logic [krt_pkg::BYTE_W-1:0]  value_b;
    logic [krt_pkg::BYTE_W-1:0]  value_c;
    logic [krt_pkg::BYTE_W-1:0]  value_d;

    modport source (
        output valid, func, key, position, value_a, value_b, value_c, value_d,
        input  ready
    );
    modport sink (
        input  valid, func, key, position, value_a, value_b, value_c, value_d,
        output ready
    );
endinterface

// Response channel: status, slot, count and the record read.
interface krt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [krt_pkg::STAT_W-1:0]  status;
    logic [krt_pkg::SLOT_W-1:0]  slot;
    logic [krt_pkg::FILL_W-1:0]  fill_count;
    logic [krt_pkg::KEY_W-1:0]   key_out;
    logic [krt_pkg::BYTE_W-1:0]  out_a;
    logic [krt_pkg::BYTE_W-1:0]  out_b;
    logic [krt_pkg::BYTE_W-1:0]  out_c;
    logic [krt_pkg::BYTE_W-1:0]  out_d;

    modport source (
        output valid, status, slot, fill_count, key_out, out_a, out_b, out_c, out_d,
        input  ready
    );
    modport sink (
        input  valid, status, slot, fill_count, key_out, out_a, out_b, out_c, out_d,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/krt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module krt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/krt_ctrl.sv
// Sequencer of the keyed record table: key search, append, shift-down delete
// and positional read over the record memory. Depends on krt_pkg, krt_if.
`default_nettype none

module krt_ctrl #(
    parameter int DEPTH = krt_pkg::DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    krt_cmd_if.sink                        cmd,
    input  wire logic                      out_free,
    output logic                           res_vld,
    output krt_pkg::res_t                  res,
    output logic                           ram_we,
    output logic [AW-1:0]                  ram_waddr,
    output logic [krt_pkg::REC_W-1:0]      ram_wdata,
    output logic [AW-1:0]                  ram_raddr,
    input  wire logic [krt_pkg::REC_W-1:0] ram_rdata
);

    krt_pkg::state_t  state_reg, state_next;
    krt_pkg::func_t   func_reg, func_next;
    krt_pkg::key_t    key_reg, key_next;
    krt_pkg::pos_t    pos_reg, pos_next;
    krt_pkg::pay_t    pay_reg, pay_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;
    krt_pkg::status_t status_reg, status_next;
    krt_pkg::slot_t   slot_reg, slot_next;
    krt_pkg::key_t    rkey_reg, rkey_next;
    krt_pkg::pay_t    rpay_reg, rpay_next;

    logic             accept;
    logic             issue;
    logic             hit;
    logic             scan_end;
    logic             full;
    logic             pos_bad;
    logic [CW-1:0]    idx_dec;
    krt_pkg::key_t    rd_key;
    krt_pkg::pay_t    rd_pay;

    // A command is taken only while the sequencer is idle.
    assign cmd.ready = (state_reg == krt_pkg::S_IDLE);

    // Status of the scan pipeline: a read is issued while the index is below
    // the count, and the entry read last cycle is compared against the key.
    assign accept   = cmd.valid && cmd.ready;
    assign rd_key   = ram_rdata[krt_pkg::KEY_W-1:0];
    assign rd_pay   = ram_rdata[krt_pkg::REC_W-1:krt_pkg::KEY_W];
    assign issue    = (idx_reg < count_reg);
    assign hit      = pend_reg && (rd_key == key_reg);
    assign scan_end = !issue && !pend_reg;
    assign full     = (count_reg >= CW'(DEPTH));
    assign pos_bad  = (32'(pos_reg) >= 32'(count_reg));
    assign idx_dec  = idx_reg - CW'(1);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            krt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (krt_pkg::func_t'(cmd.func))
                        krt_pkg::FN_INSERT: state_next = krt_pkg::S_SCAN;
                        krt_pkg::FN_REMOVE: state_next = krt_pkg::S_SCAN;
                        krt_pkg::FN_READ:   state_next = krt_pkg::S_READ;
                        default:            state_next = krt_pkg::S_DONE;
                    endcase
                end
            end
            krt_pkg::S_SCAN:
            begin
                if (hit && func_reg == krt_pkg::FN_REMOVE)
                begin
                    state_next = krt_pkg::S_SHIFT;
                end
                else if (hit || scan_end)
                begin
                    state_next = krt_pkg::S_DONE;
                end
            end
            krt_pkg::S_SHIFT:
            begin
                if (scan_end)
                begin
                    state_next = krt_pkg::S_DONE;
                end
            end
            krt_pkg::S_READ:
            begin
                state_next = pos_bad ? krt_pkg::S_DONE : krt_pkg::S_RDATA;
            end
            krt_pkg::S_RDATA:
            begin
                state_next = krt_pkg::S_DONE;
            end
            krt_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = krt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = krt_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory port and handshake outputs.
    always_comb
    begin
        func_next     = func_reg;
        key_next      = key_reg;
        pos_next      = pos_reg;
        pay_next      = pay_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        rkey_next     = rkey_reg;
        rpay_next     = rpay_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[AW-1:0];
        ram_wdata     = {pay_reg, key_reg};
        ram_raddr     = idx_reg[AW-1:0];
        res_vld       = 1'b0;
        case (state_reg)
            krt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_next   = krt_pkg::func_t'(cmd.func);
                    key_next    = cmd.key;
                    pos_next    = cmd.position;
                    pay_next    = {cmd.value_d, cmd.value_c, cmd.value_b, cmd.value_a};
                    idx_next    = '0;
                    status_next = krt_pkg::ST_OK;
                    slot_next   = '0;
                    rkey_next   = '0;
                    rpay_next   = '0;
                end
            end
            krt_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    // Key present: duplicate on insert, start of shift on remove.
                    slot_next = krt_pkg::slot_t'(pend_idx_reg);
                    if (func_reg == krt_pkg::FN_INSERT)
                    begin
                        status_next = krt_pkg::ST_DUP;
                    end
                    else
                    begin
                        idx_next = CW'(pend_idx_reg) + CW'(1);
                    end
                end
                else if (scan_end)
                begin
                    if (func_reg == krt_pkg::FN_REMOVE)
                    begin
                        status_next = krt_pkg::ST_MISSING;
                    end
                    else if (full)
                    begin
                        status_next = krt_pkg::ST_FULL;
                    end
                    else
                    begin
                        // Append the new record at the end of the table.
                        ram_we     = 1'b1;
                        slot_next  = krt_pkg::slot_t'(count_reg);
                        count_next = count_reg + CW'(1);
                    end
                end
                else
                begin
                    pend_next     = issue;
                    pend_idx_next = idx_reg[AW-1:0];
                    if (issue)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            krt_pkg::S_SHIFT:
            begin
                // Entry i+1 is read while entry i-1's successor is written back.
                ram_we    = pend_reg;
                ram_waddr = pend_idx_reg;
                ram_wdata = ram_rdata;
                if (scan_end)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    pend_next     = issue;
                    pend_idx_next = idx_dec[AW-1:0];
                    if (issue)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            krt_pkg::S_READ:
            begin
                ram_raddr = AW'(pos_reg);
                slot_next = krt_pkg::slot_t'(pos_reg);
                if (pos_bad)
                begin
                    status_next = krt_pkg::ST_RANGE;
                end
            end
            krt_pkg::S_RDATA:
            begin
                rkey_next = rd_key;
                rpay_next = rd_pay;
            end
            krt_pkg::S_DONE:
            begin
                res_vld = out_free;
            end
            default:
            begin
                res_vld = 1'b0;
            end
        endcase
    end

    // Result record as seen by the output register.
    always_comb
    begin
        res.status = status_reg;
        res.slot   = slot_reg;
        res.fill   = krt_pkg::fill_t'(count_reg);
        res.key    = rkey_reg;
        res.pay    = rpay_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= krt_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        pay_reg      <= pay_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        rkey_reg     <= rkey_next;
        rpay_reg     <= rpay_next;
    end

    // The entry count never exceeds the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above table depth");

    // The record memory is written only while searching or shifting.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == krt_pkg::S_SCAN || state_reg == krt_pkg::S_SHIFT))
        else $error("record memory written outside search or shift");

    // An append grows the count by exactly one.
    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == krt_pkg::S_SCAN) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("append did not grow the count by one");

    // A delivered result returns the sequencer to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld |=> state_reg == krt_pkg::S_IDLE)
        else $error("sequencer did not return to idle after a result");

endmodule

`default_nettype wire

>>> sv/keyed_record_table_unit.sv
// Keyed record table: up to DEPTH records of a 32-bit key and four payload
// bytes kept in insertion order in one synchronous record memory. Commands are
// insert (duplicate check, then full check, then append), remove by key (the
// later entries move down one place) and read by position; every command yields
// one response transaction with a status, a slot and the count after the
// command. Timing is set by the single read port of the record memory, which a
// search walks one entry per cycle. An insert that appends or is rejected as full,
// and a remove that misses its key, walk all stored entries; a duplicate insert
// stops at the matching entry; a remove that finds its key stops there and then
// shifts the later entries down; a read fetches the entry at its position and
// goes straight to its response when the position is out of range. A response is
// held back while the output register stays full. One command is in work at a
// time and the next is taken once the sequencer is back in idle, which it enters
// as the response is loaded. A finished response waits in an output register, so
// a new command is taken while it waits. After reset the table is empty at once;
// no clearing pass is run, since entries at or above the count are never read.
// Depends on krt_pkg, krt_if, krt_ram and krt_ctrl.
`default_nettype none

module keyed_record_table_unit #(
    parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    krt_cmd_if.sink   cmd,
    krt_rsp_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [krt_pkg::REC_W-1:0]  ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [krt_pkg::REC_W-1:0]  ram_rdata;
    logic                       out_free;
    logic                       res_vld;
    krt_pkg::res_t              res;
    logic                       rsp_valid_reg, rsp_valid_next;
    krt_pkg::res_t              rsp_reg, rsp_next;

    // Record memory: payload above key.
    krt_ram #(
        .WIDTH (krt_pkg::REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Command sequencer.
    krt_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .out_free  (out_free),
        .res_vld   (res_vld),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Output register: free when empty or when its transaction completes.
    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (res_vld)
        begin
            rsp_next       = res;
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Response channel drive.
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_reg.status;
    assign rsp.slot       = rsp_reg.slot;
    assign rsp.fill_count = rsp_reg.fill;
    assign rsp.key_out    = rsp_reg.key;
    assign rsp.out_a      = rsp_reg.pay[krt_pkg::BYTE_W-1:0];
    assign rsp.out_b      = rsp_reg.pay[2*krt_pkg::BYTE_W-1:krt_pkg::BYTE_W];
    assign rsp.out_c      = rsp_reg.pay[3*krt_pkg::BYTE_W-1:2*krt_pkg::BYTE_W];
    assign rsp.out_d      = rsp_reg.pay[4*krt_pkg::BYTE_W-1:3*krt_pkg::BYTE_W];

endmodule

`default_nettype wire
